// File: rtl/core/bmw_pkg.sv
// Shared types, constants and helpers for the binary morphology window.
// No dependencies; imported by every module of the block.
package bmw_pkg;

  localparam int KERNEL_DIM      = 3;
  localparam int KERNEL_TAPS     = KERNEL_DIM * KERNEL_DIM;
  localparam int CENTER          = (KERNEL_DIM - 1) / 2;
  localparam int LINE_BITS       = KERNEL_DIM - 1;
  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_QUEUE_DEPTH = 2;
  localparam int MAX_HEIGHT      = 1024;
  localparam int DIM_W           = 11;
  localparam int ROW_W           = $clog2(MAX_HEIGHT) + 1;  // drain runs past the last row
  localparam int OROW_W          = $clog2(MAX_HEIGHT);
  localparam int PIX_W           = 8;
  localparam int CFG_W           = DIM_W;

  localparam logic [PIX_W-1:0]       PIX_WHITE    = 8'd255;
  localparam logic [KERNEL_TAPS-1:0] MASK_RESET   = 9'h1FF;
  localparam logic [DIM_W-1:0]       WIDTH_RESET  = 11'd640;
  localparam logic [DIM_W-1:0]       HEIGHT_RESET = 11'd480;

  typedef enum logic [1:0] {
    CFG_MODE         = 2'd0,
    CFG_KERNEL_MASK  = 2'd1,
    CFG_IMAGE_WIDTH  = 2'd2,
    CFG_IMAGE_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    MODE_ERODE  = 1'b0,
    MODE_DILATE = 1'b1
  } morph_mode_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             flush;
  } bmw_in_t;

  typedef struct packed {
    logic result_pixel;
    logic end_of_frame;
  } bmw_out_t;

  // One column step for the back end.
  typedef struct packed {
    logic white;      // new bottom-row bit (0 while draining)
    logic col_first;  // column address restarts at zero
    logic emit;       // this step delivers a result
    logic border;     // result is the center pixel's own white test
    logic eof;        // last result of the frame
  } bmw_cmd_t;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int unsigned hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < DIM_W'(KERNEL_DIM)) r = DIM_W'(KERNEL_DIM);
    else if (32'(v) > hi) r = DIM_W'(hi);
    return r;
  endfunction

endpackage

// File: rtl/core/bmw_front.sv
// Front end: raster position tracking and per-beat classification.
// Depends on bmw_pkg.
module bmw_front import bmw_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             restart_i,
  input  logic [DIM_W-1:0] width_i,
  input  logic [DIM_W-1:0] height_i,
  input  logic             in_valid_i,
  input  bmw_in_t          in_data_i,
  input  logic             full_i,
  output logic             push_o,
  output bmw_cmd_t         cmd_o
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int CMP_W = (CW > DIM_W) ? CW : DIM_W;

  logic [CW-1:0]     in_col_q, in_col_d;
  logic [ROW_W-1:0]  in_row_q, in_row_d;
  logic [CW-1:0]     out_col_q, out_col_d;
  logic [OROW_W-1:0] out_row_q, out_row_d;

  logic accept, writing, in_last_col, out_last_col, out_last_row, emit;

  always_comb begin
    accept       = in_valid_i && !full_i;
    writing      = in_row_q < ROW_W'(height_i);
    in_last_col  = CMP_W'(in_col_q) == (CMP_W'(width_i) - CMP_W'(1));
    out_last_col = CMP_W'(out_col_q) == (CMP_W'(width_i) - CMP_W'(1));
    out_last_row = out_row_q == OROW_W'(height_i - DIM_W'(1));
    // results start one row plus one pixel behind the input
    emit = (in_row_q > ROW_W'(1)) || ((in_row_q == ROW_W'(1)) && (in_col_q != '0));

    cmd_o.white     = writing && (in_data_i.pixel_value == PIX_WHITE);
    cmd_o.col_first = (in_col_q == '0);
    cmd_o.emit      = emit;
    cmd_o.border    = (out_row_q == '0) || out_last_row || (out_col_q == '0) || out_last_col;
    cmd_o.eof       = emit && out_last_row && out_last_col;

    // a flush while pixels are still due is dropped without effect
    push_o = accept && !(writing && in_data_i.flush);

    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (push_o) begin
      if (in_last_col) begin
        in_col_d = '0;
        in_row_d = in_row_q + ROW_W'(1);
      end else begin
        in_col_d = in_col_q + CW'(1);
      end
      if (emit) begin
        if (out_last_col) begin
          out_col_d = '0;
          out_row_d = out_row_q + OROW_W'(1);
        end else begin
          out_col_d = out_col_q + CW'(1);
        end
      end
      if (cmd_o.eof) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end
    end
    if (restart_i) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

endmodule

// File: rtl/core/bmw_fifo.sv
// Short command queue between front and back end.
// Depends on bmw_pkg for the command type.
module bmw_fifo import bmw_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  bmw_cmd_t data_i,
  input  logic     pop_i,
  output bmw_cmd_t data_o,
  output logic     valid_o,
  output logic     full_o
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  bmw_cmd_t        entries_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0] count_q, count_d;

  always_comb begin
    full_o   = (count_q == CNTW'(DEPTH));
    valid_o  = (count_q != '0);
    data_o   = entries_q[rd_ptr_q];
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    if (pop_i)  rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    if (push_i && !pop_i) count_d = count_q + CNTW'(1);
    else if (pop_i && !push_i) count_d = count_q - CNTW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entries_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: rtl/core/bmw_back.sv
// Back end: line memory read-modify-write, 3x3 window and result register.
// Depends on bmw_pkg.
module bmw_back import bmw_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  morph_mode_e            mode_i,
  input  logic [KERNEL_TAPS-1:0] mask_i,
  input  bmw_cmd_t               cmd_i,
  input  logic                   cmd_valid_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output bmw_out_t               out_data_o
);

  localparam int CW = $clog2(MAX_WIDTH);

  // each entry: bits of the two rows above the incoming one, older row in the MSB
  logic [LINE_BITS-1:0] line_mem_q [MAX_WIDTH];
  logic [LINE_BITS-1:0] rdata_q;

  logic          s1_valid_q;
  bmw_cmd_t      s1_cmd_q;
  logic [CW-1:0] s1_addr_q, addr_d;

  logic [KERNEL_DIM-1:0][KERNEL_DIM-1:0] win_q, win_d;  // [row][col], row 0 on top
  logic [KERNEL_DIM-1:0]                 new_col;
  logic [KERNEL_TAPS-1:0]                taps;

  logic     advance, wr_en, all_white, any_white, win_res, own_res;
  logic     out_valid_q;
  bmw_out_t out_data_q;

  always_comb begin
    advance = !out_valid_q || !out_stall_i;
    pop_o   = advance && cmd_valid_i;
    wr_en   = advance && s1_valid_q;
    addr_d  = cmd_i.col_first ? '0 : s1_addr_q + CW'(1);

    new_col[0] = rdata_q[1];
    new_col[1] = rdata_q[0];
    new_col[2] = s1_cmd_q.white;
    for (int r = 0; r < KERNEL_DIM; r++) begin
      win_d[r] = {new_col[r], win_q[r][KERNEL_DIM-1:1]};
    end

    taps      = win_d;
    all_white = &(taps | ~mask_i);
    any_white = |(taps & mask_i);
    win_res   = (mode_i == MODE_DILATE) ? !any_white : !all_white;
    own_res   = !win_d[CENTER][CENTER];

    out_valid_o = out_valid_q;
    out_data_o  = out_data_q;
  end

  // line memory: one read for the next column, one write-back for the current one
  always_ff @(posedge clk_i) begin
    if (pop_o) rdata_q <= line_mem_q[addr_d];
    if (wr_en) line_mem_q[s1_addr_q] <= {rdata_q[0], s1_cmd_q.white};
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) s1_cmd_q <= cmd_i;
    if (advance) begin
      out_data_q.result_pixel <= s1_cmd_q.border ? own_res : win_res;
      out_data_q.end_of_frame <= s1_cmd_q.eof;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_addr_q   <= '0;
      out_valid_q <= 1'b0;
      win_q       <= '0;
    end else begin
      if (advance) begin
        s1_valid_q  <= cmd_valid_i;
        out_valid_q <= s1_valid_q && s1_cmd_q.emit;
      end
      if (pop_o) s1_addr_q <= addr_d;
      if (wr_en) win_q <= win_d;
    end
  end

endmodule

// File: rtl/core/binary_morphology_window.sv
// Streaming 3x3 binary erosion/dilation. Throughput: one beat per cycle unless the
// output stalls, set by the single read-modify-write of the line memory per column.
// A result passes the queue, stage 1 and the result register after the beat that
// completes its window. Reset (async, low): position counters, pipeline valids and
// window clear, registers return to defaults; the line memory is not cleared and
// needs no clearing pass. Depends on bmw_pkg, bmw_front, bmw_fifo, bmw_back.
module binary_morphology_window import bmw_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration write port
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  // pixel input
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  bmw_in_t          in_data_i,
  // result output
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output bmw_out_t         out_data_o
);

  // Configuration registers. Sizes are stored already clamped; a size write
  // restarts the frame position in the front end.
  morph_mode_e            mode_q;
  logic [KERNEL_TAPS-1:0] mask_q;
  logic [DIM_W-1:0]       width_q, height_q;
  logic                   restart;

  always_comb begin
    restart = cfg_we_i && ((cfg_idx_i == CFG_IMAGE_WIDTH) || (cfg_idx_i == CFG_IMAGE_HEIGHT));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_ERODE;
      mask_q   <= MASK_RESET;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:         mode_q   <= morph_mode_e'(cfg_wdata_i[0]);
        CFG_KERNEL_MASK:  mask_q   <= cfg_wdata_i[KERNEL_TAPS-1:0];
        CFG_IMAGE_WIDTH:  width_q  <= clamp_dim(cfg_wdata_i, MAX_WIDTH);
        CFG_IMAGE_HEIGHT: height_q <= clamp_dim(cfg_wdata_i, MAX_HEIGHT);
        default: ;
      endcase
    end
  end

  // Front end: tracks the raster position of input and output, drops early
  // flushes, turns late pixels into drain steps, and tags each step with
  // whether it emits, whether the result is a border pass-through and eof.
  logic     fifo_full, fifo_valid, front_push, back_pop;
  bmw_cmd_t front_cmd, fifo_cmd;

  assign in_stall_o = fifo_full;

  bmw_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .width_i   (width_q),
    .height_i  (height_q),
    .in_valid_i(in_valid_i),
    .in_data_i (in_data_i),
    .full_i    (fifo_full),
    .push_o    (front_push),
    .cmd_o     (front_cmd)
  );

  // Command queue: two entries keep one beat per cycle while the output is not stalled,
  // as the full flag comes from the registered count and does not see a pop in that cycle.
  bmw_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_push),
    .data_i (front_cmd),
    .pop_i  (back_pop),
    .data_o (fifo_cmd),
    .valid_o(fifo_valid),
    .full_o (fifo_full)
  );

  // Back end: stage 1 reads the line memory, stage 2 writes it back, shifts the
  // window and loads the result register; the whole pipe holds while a
  // finished result is stalled.
  bmw_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mode_i     (mode_q),
    .mask_i     (mask_q),
    .cmd_i      (fifo_cmd),
    .cmd_valid_i(fifo_valid),
    .pop_o      (back_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // A stalled result must freeze the back end.
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !back_pop)
    else $error("back end popped while its result was stalled");

  // The front end never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_push |-> !fifo_full)
    else $error("command queue overflow");

  // The frame's last result is the bottom-right corner, always a border pixel.
  a_eof_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front_push && front_cmd.eof) |-> (front_cmd.emit && front_cmd.border))
    else $error("end of frame tagged on a non-border result");

endmodule

// File: dv/tb_binary_morphology_window.sv
// Self-checking testbench for binary_morphology_window: streams raster frames through the
// 3x3 erode/dilate window and checks every result beat against an in-bench predictor.
// Depends on bmw_pkg and the binary_morphology_window RTL.
module tb_binary_morphology_window;
  timeunit 1ns;
  timeprecision 1ps;
  import bmw_pkg::*;

  localparam int BOT = KERNEL_DIM - 1 - CENTER;  // rows/pixels below and right of center

  // DUT ports; every input starts at a known value
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [1:0]       cfg_idx_i   = CFG_MODE;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  bmw_in_t          in_data_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b1;
  bmw_out_t         out_data_o;

  // Predictor state: white bits of the last KERNEL_DIM rows plus frame position
  logic                   white_rows [KERNEL_DIM][DEF_MAX_WIDTH];
  int unsigned            in_row, in_col, out_count;
  morph_mode_e            cur_mode  = MODE_ERODE;
  logic [KERNEL_TAPS-1:0] cur_mask  = MASK_RESET;
  logic [DIM_W-1:0]       img_w     = WIDTH_RESET;
  logic [DIM_W-1:0]       img_h     = HEIGHT_RESET;

  bmw_out_t    pending_results [$];
  int unsigned errors, beats_sent, results_seen, frames_done, random_items, hold_runs;

  // Stimulus knobs, changed per phase
  int unsigned src_idle_max  = 0;
  int unsigned sink_idle_max = 0;
  int unsigned hold_cycles   = 0;   // one-shot long output hold-off, in cycles
  int unsigned white_pct     = 50;

  binary_morphology_window dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Size registers are used clamped to [KERNEL_DIM, hi].
  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
    if (v < KERNEL_DIM) return KERNEL_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void frame_restart();
    in_row    = 0;
    in_col    = 0;
    out_count = 0;
  endfunction

  function automatic void apply_cfg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    case (idx)
      CFG_MODE:         cur_mode = morph_mode_e'(val[0]);
      CFG_KERNEL_MASK:  cur_mask = val[KERNEL_TAPS-1:0];
      CFG_IMAGE_WIDTH: begin
        img_w = val;
        frame_restart();  // size change aborts the frame in flight
      end
      CFG_IMAGE_HEIGHT: begin
        img_h = val;
        frame_restart();
      end
      default: ;
    endcase
  endfunction

  // Advances the window by one accepted beat; returns 1 when a result pixel is due.
  function automatic bit morph_predict(input bmw_in_t beat, output bmw_out_t res);
    int unsigned w, h, total, pos, ro, co;
    bit          all_white, any_white, px;
    w     = eff_dim(img_w, DEF_MAX_WIDTH);
    h     = eff_dim(img_h, MAX_HEIGHT);
    total = w * h;
    pos   = in_row * w + in_col;
    res   = '0;
    if (pos < total) begin
      if (beat.flush) return 0;  // flush ahead of the last pixel is dropped
      white_rows[in_row % KERNEL_DIM][in_col] = (beat.pixel_value == PIX_WHITE);
    end
    // past the last pixel a pixel beat just drains, like a flush
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (pos + 1 <= BOT * w + BOT) return 0;

    ro = out_count / w;
    co = out_count % w;
    if (ro >= CENTER && ro + BOT < h && co >= CENTER && co + BOT < w) begin
      all_white = 1'b1;
      any_white = 1'b0;
      for (int dr = 0; dr < KERNEL_DIM; dr++) begin
        for (int dc = 0; dc < KERNEL_DIM; dc++) begin
          if (cur_mask[dr * KERNEL_DIM + dc]) begin
            px = white_rows[(ro - CENTER + dr) % KERNEL_DIM][co - CENTER + dc];
            if (px) any_white = 1'b1;
            else all_white = 1'b0;
          end
        end
      end
      res.result_pixel = (cur_mode == MODE_DILATE) ? !any_white : !all_white;
    end else begin
      // window off the image edge: pixel passes through as its own white test
      res.result_pixel = !white_rows[ro % KERNEL_DIM][co];
    end
    out_count++;
    res.end_of_frame = (out_count >= total);
    if (res.end_of_frame) frame_restart();
    return 1;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Registers are only written while nothing is pending.
  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_cfg(idx, val);
    @(posedge clk_i);
  endtask

  // Offers one beat and holds it until taken. The idle gap comes after the beat,
  // so back-to-back beats keep valid high without a low/high pair in one step.
  task automatic send_beat(input logic [PIX_W-1:0] pix, input logic flush);
    bmw_in_t     beat;
    bmw_out_t    res;
    int unsigned gap;
    beat.pixel_value = pix;
    beat.flush       = flush;
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
    if (morph_predict(beat, res)) pending_results.push_back(res);
    gap = $urandom_range(0, src_idle_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drops valid, waits for every predicted result, then lets the pipeline settle
  // (beats that yield nothing may still be in flight).
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    if ($urandom_range(0, 99) < white_pct) return PIX_WHITE;
    return PIX_W'($urandom_range(0, 254));
  endfunction

  // Pixels of a frame, with optional stray flushes mixed in ahead of the last pixel.
  task automatic push_frame(input int unsigned npix, input int unsigned noise_pct);
    for (int unsigned i = 0; i < npix; i++) begin
      if ($urandom_range(0, 99) < noise_pct) send_beat(rand_pixel(), 1'b1);
      send_beat(rand_pixel(), 1'b0);
    end
  endtask

  // Tail drain: a mix of flushes and surplus pixels, which count as flushes.
  task automatic push_drain(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) != 0) send_beat(PIX_W'($urandom), 1'b1);
      else send_beat(rand_pixel(), 1'b0);
    end
  endtask

  task automatic run_frame(input int unsigned noise_pct);
    int unsigned w;
    w = eff_dim(img_w, DEF_MAX_WIDTH);
    push_frame(w * eff_dim(img_h, MAX_HEIGHT), noise_pct);
    push_drain(BOT * w + BOT);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls plus an optional long hold-off
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned n;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_cycles != 0) begin
        n           = hold_cycles;
        hold_cycles = 0;
        hold_runs++;
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      n = $urandom_range(0, sink_idle_max);
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic void flag_error(input string what, input logic want, input logic got);
    errors++;
    if (errors <= 10)
      $display("%0t: %s mismatch, expected %b got %b", $time, what, want, got);
  endfunction

  // Every accepted result beat is matched against the oldest prediction.
  always @(posedge clk_i) begin : result_check
    bmw_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        flag_error("unexpected beat, result_pixel", 1'bx, out_data_o.result_pixel);
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (out_data_o.result_pixel !== want.result_pixel)
          flag_error("result_pixel", want.result_pixel, out_data_o.result_pixel);
        if (out_data_o.end_of_frame !== want.end_of_frame)
          flag_error("end_of_frame", want.end_of_frame, out_data_o.end_of_frame);
        if (want.end_of_frame) frames_done++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset defaults are 640x480: a short burst fills only part of the first row,
  // so nothing comes out; the next size write throws the partial frame away.
  task automatic test_default_partial();
    src_idle_max  = 16;
    sink_idle_max = 16;
    white_pct     = 50;
    push_frame(20, 20);
    wait_idle();
  endtask

  // Smallest frames, hand-picked pixels: erosion with the full mask, then dilation
  // with an empty mask; stray flush mid-frame, surplus pixel in the drain, and a
  // flush after the frame has closed.
  task automatic test_directed();
    logic [PIX_W-1:0] frame_a [9] = '{8'd255, 8'd0, 8'd255, 8'd127, 8'd255,
                                      8'd128, 8'd255, 8'd1, 8'd254};
    cfg_write(CFG_IMAGE_WIDTH, CFG_W'(KERNEL_DIM));
    cfg_write(CFG_IMAGE_HEIGHT, CFG_W'(KERNEL_DIM));
    cfg_write(CFG_MODE, CFG_W'(MODE_ERODE));
    cfg_write(CFG_KERNEL_MASK, CFG_W'(MASK_RESET));
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_beat(PIX_WHITE, 1'b1);  // ignored, frame not complete
      send_beat(frame_a[i], 1'b0);
    end
    send_beat(PIX_WHITE, 1'b1);
    send_beat(PIX_WHITE, 1'b0);                // surplus pixel drains like a flush
    send_beat(8'd0, 1'b1);
    send_beat(8'd0, 1'b1);                     // closes the frame
    send_beat(PIX_WHITE, 1'b1);                // nothing pending: ignored
    wait_idle();

    cfg_write(CFG_MODE, CFG_W'(MODE_DILATE));
    cfg_write(CFG_KERNEL_MASK, '0);
    for (int i = 0; i < 9; i++) send_beat(PIX_WHITE, 1'b0);
    for (int i = 0; i < 4; i++) send_beat(8'd0, 1'b1);
    wait_idle();
  endtask

  // Out-of-range sizes clamp: 2047 wide runs as the 1024 maximum, so a short
  // burst stays inside the first row and yields nothing; then 0 wide and 2 high
  // both run as 3 for a full frame.
  task automatic test_size_clamp();
    src_idle_max  = 16;
    sink_idle_max = 16;
    white_pct     = 70;
    cfg_write(CFG_IMAGE_WIDTH, CFG_W'(2047));
    cfg_write(CFG_IMAGE_HEIGHT, '0);
    cfg_write(CFG_KERNEL_MASK, CFG_W'(MASK_RESET));
    cfg_write(CFG_MODE, CFG_W'(MODE_ERODE));
    push_frame(40, 0);
    wait_idle();
    cfg_write(CFG_IMAGE_WIDTH, '0);
    cfg_write(CFG_IMAGE_HEIGHT, CFG_W'(2));
    cfg_write(CFG_MODE, CFG_W'(MODE_DILATE));
    cfg_write(CFG_KERNEL_MASK, CFG_W'(9'h0BA));
    white_pct = 20;
    run_frame(5);
    wait_idle();
  endtask

  // Size writes in the middle of a frame restart it: once via width, once via
  // height, then a clean frame to show the counters came back to zero.
  task automatic test_frame_abort();
    src_idle_max  = 16;
    sink_idle_max = 16;
    white_pct     = 60;
    cfg_write(CFG_IMAGE_WIDTH, CFG_W'(5));
    cfg_write(CFG_IMAGE_HEIGHT, CFG_W'(2047));
    cfg_write(CFG_MODE, CFG_W'(MODE_ERODE));
    push_frame(22, 10);
    wait_idle();
    cfg_write(CFG_IMAGE_WIDTH, CFG_W'(4));
    push_frame(7, 0);
    wait_idle();
    cfg_write(CFG_IMAGE_HEIGHT, CFG_W'(KERNEL_DIM));
    run_frame(10);
    wait_idle();
  endtask

  // Output held off for a long stretch while input runs flat out, so the block
  // backs up and stalls its input.
  task automatic test_backpressure();
    src_idle_max  = 0;
    sink_idle_max = 0;
    white_pct     = 50;
    cfg_write(CFG_IMAGE_WIDTH, CFG_W'(10));
    cfg_write(CFG_IMAGE_HEIGHT, CFG_W'(6));
    cfg_write(CFG_KERNEL_MASK, CFG_W'(9'h1EF));
    hold_cycles = 300;
    run_frame(0);
    wait_idle();
  endtask

  // Random frames: random size, mode, mask and white density; some frames carry
  // stray flushes, some are cut short and aborted by the next size write.
  task automatic test_random_frames();
    int unsigned            frame_no, w, h, npix;
    logic [DIM_W-1:0]       wv, hv;
    logic [KERNEL_TAPS-1:0] mv;
    morph_mode_e            md;
    frame_no = 0;
    while (random_items < 200) begin
      wait_idle();
      src_idle_max  = ($urandom_range(0, 3) == 0) ? 0 : 16;
      sink_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
      white_pct     = $urandom_range(0, 100);
      case ($urandom_range(0, 7))
        0:       wv = DIM_W'($urandom_range(0, 2));
        1:       wv = DIM_W'(KERNEL_DIM);
        default: wv = DIM_W'($urandom_range(4, 12));
      endcase
      case ($urandom_range(0, 7))
        0:       hv = DIM_W'($urandom_range(0, 2));
        1:       hv = DIM_W'(KERNEL_DIM);
        default: hv = DIM_W'($urandom_range(4, 7));
      endcase
      case ($urandom_range(0, 7))
        0:       mv = '0;
        1:       mv = MASK_RESET;
        default: mv = KERNEL_TAPS'($urandom_range(1, 510));
      endcase
      md = morph_mode_e'($urandom_range(0, 1));
      // first two frames pin the erosion/empty-mask and dilation/full-mask corners
      if (frame_no == 0) begin
        md = MODE_ERODE;
        mv = '0;
      end else if (frame_no == 1) begin
        md = MODE_DILATE;
        mv = MASK_RESET;
      end
      cfg_write(CFG_IMAGE_WIDTH, CFG_W'(wv));
      cfg_write(CFG_IMAGE_HEIGHT, CFG_W'(hv));
      cfg_write(CFG_MODE, CFG_W'(md));
      cfg_write(CFG_KERNEL_MASK, CFG_W'(mv));
      w    = eff_dim(wv, DEF_MAX_WIDTH);
      h    = eff_dim(hv, MAX_HEIGHT);
      npix = w * h;
      if (frame_no > 1 && $urandom_range(0, 5) == 0) begin
        npix = $urandom_range(1, w * h - 1);
        push_frame(npix, 10);
        random_items += npix;
      end else begin
        push_frame(npix, ($urandom_range(0, 1) != 0) ? 10 : 0);
        push_drain(BOT * w + BOT);
        random_items += npix + BOT * w + BOT;
      end
      frame_no++;
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : test_sequence
    for (int r = 0; r < KERNEL_DIM; r++)
      for (int c = 0; c < DEF_MAX_WIDTH; c++) white_rows[r][c] = 1'b0;
    frame_restart();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_partial();
    test_directed();
    test_size_clamp();
    test_frame_abort();
    test_backpressure();
    test_random_frames();

    $display("Sent %0d beats, checked %0d results over %0d complete frames.",
             beats_sent, results_seen, frames_done);
    $display("Covered erode/dilate, mask and size sweeps incl. clamping, aborts, %0d hold-offs.",
             hold_runs);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS binary_morphology_window");
    end else begin
      $display("%0d errors, %0d results outstanding", errors, pending_results.size());
      $display("FAIL binary_morphology_window");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin : watchdog
    #(5ms);
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("FAIL binary_morphology_window");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/bmw_pkg.sv
rtl/core/bmw_front.sv
rtl/core/bmw_fifo.sv
rtl/core/bmw_back.sv
rtl/core/binary_morphology_window.sv
dv/tb_binary_morphology_window.sv
